[design/radix_tree_block_lookup_assert.svh]
// Assertion macros for the radix tree block lookup.
`ifndef RADIX_TREE_BLOCK_LOOKUP_ASSERT_SVH
`define RADIX_TREE_BLOCK_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define RTBL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rtbl: same-cycle check failed");
`define RTBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtbl: next-cycle check failed");
`else
`define RTBL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define RTBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/rtbl_pkg.sv]
// Shared types and constants for the radix tree block lookup.
package rtbl_pkg;
	localparam int VBA_W      = 48;
	localparam int PBA_OUT_W  = 32;
	localparam int ENTRY_IN_W = 32;
	localparam int NODE_W     = 8;
	localparam int SLOT_IN_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 49;
	localparam int DEG_REG_W  = 3;
	localparam int HGT_REG_W  = 4;
	localparam int LEAF_W     = 49;
	localparam int ROOT_W     = 8;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_STORE = 2'd2
	} status_t;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAVES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT   = 2'd3;
endpackage

[design/radix_tree_block_lookup.sv]
// Top level: walk sequencer, configuration registers and result registers.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  command  | start, busy            | func, node_block, slot, entry_value, vba
//  result   | done (one-cycle pulse) | pba, status
//  config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// A write or an out-of-range lookup gives done in the cycle after acceptance.
// A lookup holds busy through S_WALK, one node memory read per level, and
// then S_FINISH, and gives done as it returns to idle.
// A block number out of store ends the walk early. The node store is not
// cleared on reset. The receiver cannot stall; done is never withheld.
module radix_tree_block_lookup #(
	parameter int NUM_BLOCKS      = 256,
	parameter int MAX_DEGREE_LOG2 = 6,
	parameter int MAX_HEIGHT      = 8,
	parameter int PBA_WIDTH       = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                func,
	input  logic [rtbl_pkg::NODE_W-1:0]         node_block,
	input  logic [rtbl_pkg::SLOT_IN_W-1:0]      slot,
	input  logic [rtbl_pkg::ENTRY_IN_W-1:0]     entry_value,
	input  logic [rtbl_pkg::VBA_W-1:0]          vba,
	output logic                                done,
	output logic [rtbl_pkg::PBA_OUT_W-1:0]      pba,
	output logic [1:0]                          status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rtbl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rtbl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	localparam int NB_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int AW     = NB_W + MAX_DEGREE_LOG2;
	localparam int DEPTH  = NUM_BLOCKS * (1 << MAX_DEGREE_LOG2);
	localparam int NBC_W  = $clog2(NUM_BLOCKS + 1);
	localparam int WB_W   = (NBC_W > rtbl_pkg::NODE_W) ? NBC_W : rtbl_pkg::NODE_W;
	localparam int CMP_W  = (NBC_W > PBA_WIDTH) ? NBC_W : PBA_WIDTH;
	localparam int SC_W   = (MAX_DEGREE_LOG2 + 1 > rtbl_pkg::SLOT_IN_W) ?
		MAX_DEGREE_LOG2 + 1 : rtbl_pkg::SLOT_IN_W;
	localparam int BW     = $clog2(MAX_DEGREE_LOG2 + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int PW     = $clog2(MAX_DEGREE_LOG2 * MAX_HEIGHT + 1);

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

	state_t state_q;

	// configuration
	logic [rtbl_pkg::DEG_REG_W-1:0] degree_q;
	logic [rtbl_pkg::HGT_REG_W-1:0] height_q;
	logic [rtbl_pkg::LEAF_W-1:0]    leaves_q;
	logic [rtbl_pkg::ROOT_W-1:0]    root_q;

	// walk registers
	logic [rtbl_pkg::VBA_W-1:0] vba_q;
	logic [PW-1:0]              pos_q;
	logic [BW-1:0]              bits_q;
	logic [HW-1:0]              lvl_q;
	logic                       first_q;

	logic                           done_q;
	logic [rtbl_pkg::PBA_OUT_W-1:0] pba_q;
	rtbl_pkg::status_t              status_q;

	logic                    accept;
	logic                    wr_ok;
	logic                    in_range;
	logic [BW-1:0]           bits_c;
	logic [HW-1:0]           height_c;
	logic [PW-1:0]           pos_c;
	logic [PBA_WIDTH-1:0]    cur_blk;
	logic                    cur_ok;
	logic [MAX_DEGREE_LOG2-1:0] digit;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr;
	logic [PBA_WIDTH-1:0]    mem_rdata;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign done      = done_q;
	assign pba       = pba_q;
	assign status    = status_q;

	always_comb begin
		wr_ok = (WB_W'(node_block) < WB_W'(NUM_BLOCKS)) &&
			(SC_W'(slot) < SC_W'(1 << MAX_DEGREE_LOG2));
		in_range = {1'b0, vba} < leaves_q;

		if (degree_q == '0) begin
			bits_c = BW'(1);
		end else if ({1'b0, degree_q} > 4'(MAX_DEGREE_LOG2)) begin
			bits_c = BW'(MAX_DEGREE_LOG2);
		end else begin
			bits_c = BW'(degree_q);
		end

		if (height_q == '0) begin
			height_c = HW'(1);
		end else if ({1'b0, height_q} > 5'(MAX_HEIGHT)) begin
			height_c = HW'(MAX_HEIGHT);
		end else begin
			height_c = HW'(height_q);
		end

		// position of the most significant digit
		pos_c = PW'(bits_c) * PW'(height_c - HW'(1));

		cur_blk = first_q ? PBA_WIDTH'(root_q) : mem_rdata;
		cur_ok  = CMP_W'(cur_blk) < CMP_W'(NUM_BLOCKS);

		mem_we    = accept && (func == rtbl_pkg::FUNC_WRITE) && wr_ok;
		mem_waddr = {NB_W'(node_block), MAX_DEGREE_LOG2'(slot)};
		mem_re    = (state_q == S_WALK) && cur_ok;
		mem_raddr = {NB_W'(cur_blk), digit};
	end

	rtbl_digit #(
		.MAX_DEG (MAX_DEGREE_LOG2),
		.BW      (BW),
		.PW      (PW)
	) u_digit (
		.vba   (vba_q),
		.pos   (pos_q),
		.bits  (bits_q),
		.digit (digit)
	);

	rtbl_node_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (PBA_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (PBA_WIDTH'(entry_value)),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= rtbl_pkg::DEG_REG_W'(1);
			height_q <= rtbl_pkg::HGT_REG_W'(1);
			leaves_q <= '0;
			root_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rtbl_pkg::CFG_DEGREE: degree_q <= cfg_data[rtbl_pkg::DEG_REG_W-1:0];
				rtbl_pkg::CFG_HEIGHT: height_q <= cfg_data[rtbl_pkg::HGT_REG_W-1:0];
				rtbl_pkg::CFG_LEAVES: leaves_q <= cfg_data[rtbl_pkg::LEAF_W-1:0];
				rtbl_pkg::CFG_ROOT:   root_q   <= cfg_data[rtbl_pkg::ROOT_W-1:0];
				default: ;
			endcase
		end
	end

	// walk payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			vba_q   <= vba;
			pos_q   <= pos_c;
			bits_q  <= bits_c;
			lvl_q   <= height_c;
			first_q <= 1'b1;
		end else if (state_q == S_WALK) begin
			pos_q   <= pos_q - PW'(bits_q);
			lvl_q   <= lvl_q - HW'(1);
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			pba_q    <= '0;
			status_q <= rtbl_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == rtbl_pkg::FUNC_WRITE) begin
							done_q   <= 1'b1;
							pba_q    <= '0;
							status_q <= wr_ok ? rtbl_pkg::ST_OK : rtbl_pkg::ST_STORE;
						end else if (!in_range) begin
							done_q   <= 1'b1;
							pba_q    <= '0;
							status_q <= rtbl_pkg::ST_RANGE;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (!cur_ok) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						pba_q    <= '0;
						status_q <= rtbl_pkg::ST_STORE;
					end else if (lvl_q == HW'(1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					pba_q    <= rtbl_pkg::PBA_OUT_W'(mem_rdata);
					status_q <= rtbl_pkg::ST_OK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "radix_tree_block_lookup_assert.svh"

	`RTBL_ASSERT_IMPLIES(a_done_when_idle, clk, arst_n, done, !busy)
	`RTBL_ASSERT_IMPLIES(a_err_zero_pba, clk, arst_n, done && (status != rtbl_pkg::ST_OK), pba == '0)
	`RTBL_ASSERT_NEXT(a_walk_starts, clk, arst_n, accept && (func == rtbl_pkg::FUNC_LOOKUP) && in_range, busy && !done)
	`RTBL_ASSERT_NEXT(a_write_answers, clk, arst_n, accept && (func == rtbl_pkg::FUNC_WRITE), done && !busy)
endmodule

[design/rtbl_node_mem.sv]
// Node store: single write port, single registered read port.
module rtbl_node_mem #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[design/rtbl_digit.sv]
// Digit extractor: shifts the address right by the level position and masks.
module rtbl_digit #(
	parameter int MAX_DEG = 6,
	parameter int BW      = 3,
	parameter int PW      = 6
) (
	input  logic [rtbl_pkg::VBA_W-1:0] vba,
	input  logic [PW-1:0]              pos,
	input  logic [BW-1:0]              bits,
	output logic [MAX_DEG-1:0]         digit
);
	localparam int SW = MAX_DEG + 1;

	logic [rtbl_pkg::VBA_W-1:0] shifted;
	logic [SW-1:0]              one_sh;
	logic [MAX_DEG-1:0]         mask;

	always_comb begin
		shifted = vba >> pos;
		one_sh  = SW'(1) << bits;
		// wraps to all ones when bits equals the full digit width
		mask    = one_sh[MAX_DEG-1:0] - MAX_DEG'(1);
		digit   = shifted[MAX_DEG-1:0] & mask;
	end
endmodule

[dv/testbench.sv]
// Self-checking testbench for the radix tree block lookup: node writes and address walks.
`timescale 1ns / 1ps

module testbench;
	localparam int NUM_BLOCKS = 256;
	localparam int MAX_DEG    = 6;
	localparam int MAX_HGT    = 8;
	localparam int SLOTS      = 1 << MAX_DEG;
	localparam int WATCHDOG   = 1000;
	localparam logic [rtbl_pkg::LEAF_W-1:0] ALL_LEAVES = 49'h1_0000_0000_0000;
	localparam logic [rtbl_pkg::LEAF_W-1:0] LEAF_ONES  = 49'h1_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {JOB_CMD, JOB_CFG, JOB_DRAIN} job_kind_t;

	typedef struct packed {
		job_kind_t                          kind;
		logic                               func_b;
		logic [rtbl_pkg::NODE_W-1:0]        nb;
		logic [rtbl_pkg::SLOT_IN_W-1:0]     sl;
		logic [rtbl_pkg::ENTRY_IN_W-1:0]    ev;
		logic [rtbl_pkg::VBA_W-1:0]         va;
		logic [rtbl_pkg::CFG_IDX_W-1:0]     idx;
		logic [rtbl_pkg::CFG_DATA_W-1:0]    data;
		logic [7:0]                         gap;
	} job_t;

	typedef struct packed {
		logic [rtbl_pkg::PBA_OUT_W-1:0] pba;
		rtbl_pkg::status_t              status;
	} xlat_t;

	logic                             clk         = 1'b0;
	logic                             arst_n      = 1'b0;
	logic                             start       = 1'b0;
	logic                             func        = 1'b0;
	logic [rtbl_pkg::NODE_W-1:0]      node_block  = '0;
	logic [rtbl_pkg::SLOT_IN_W-1:0]   slot        = '0;
	logic [rtbl_pkg::ENTRY_IN_W-1:0]  entry_value = '0;
	logic [rtbl_pkg::VBA_W-1:0]       vba         = '0;
	logic                             cfg_valid   = 1'b0;
	logic [rtbl_pkg::CFG_IDX_W-1:0]   cfg_index   = '0;
	logic [rtbl_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;
	logic                             busy;
	logic                             done;
	logic [rtbl_pkg::PBA_OUT_W-1:0]   pba;
	logic [1:0]                       status;
	logic                             cfg_ready;

	job_t  job_q[$];
	xlat_t due_xlat[$];

	// predicted block state
	logic [rtbl_pkg::ENTRY_IN_W-1:0] node_mem [NUM_BLOCKS][SLOTS];
	logic [rtbl_pkg::DEG_REG_W-1:0]  deg_reg    = 3'd1;
	logic [rtbl_pkg::HGT_REG_W-1:0]  hgt_reg    = 4'd1;
	logic [rtbl_pkg::LEAF_W-1:0]     leaves_reg = '0;
	logic [rtbl_pkg::ROOT_W-1:0]     root_reg   = '0;

	// stimulus bookkeeping: nodes that are fully written and may be walked
	logic [rtbl_pkg::NODE_W-1:0]     walk_nodes [4];
	logic [rtbl_pkg::LEAF_W-1:0]     gen_leaves = '0;
	bit                              idle_on    = 1'b1;

	logic                  cmd_taken     = 1'b0;
	logic                  cfg_taken     = 1'b0;
	logic [7:0]            gap_waited    = '0;
	int                    idle_cycles   = 0;
	int                    mismatch_count = 0;

	radix_tree_block_lookup #(
		.NUM_BLOCKS      (NUM_BLOCKS),
		.MAX_DEGREE_LOG2 (MAX_DEG),
		.MAX_HEIGHT      (MAX_HGT),
		.PBA_WIDTH       (32)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.node_block  (node_block),
		.slot        (slot),
		.entry_value (entry_value),
		.vba         (vba),
		.done        (done),
		.pba         (pba),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Effect and answer of one command on the predicted state.
	function automatic xlat_t translate_item(input logic f,
			input logic [rtbl_pkg::NODE_W-1:0] nb,
			input logic [rtbl_pkg::SLOT_IN_W-1:0] sl,
			input logic [rtbl_pkg::ENTRY_IN_W-1:0] ev,
			input logic [rtbl_pkg::VBA_W-1:0] va);
		xlat_t r;
		int unsigned bits, levels, pos, lvl;
		logic [63:0] blk, digit;
		r.pba = '0;
		r.status = rtbl_pkg::ST_OK;
		if (f == rtbl_pkg::FUNC_WRITE) begin
			if (nb >= NUM_BLOCKS || sl >= SLOTS)
				r.status = rtbl_pkg::ST_STORE;
			else
				node_mem[nb][sl] = ev;
		end else if (va >= leaves_reg) begin
			r.status = rtbl_pkg::ST_RANGE;
		end else begin
			bits = (deg_reg == 0) ? 1 : (deg_reg > MAX_DEG) ? MAX_DEG : deg_reg;
			levels = (hgt_reg == 0) ? 1 : (hgt_reg > MAX_HGT) ? MAX_HGT : hgt_reg;
			blk = 64'(root_reg);
			lvl = levels;
			while (lvl >= 1 && r.status == rtbl_pkg::ST_OK) begin
				if (blk >= NUM_BLOCKS) begin
					r.status = rtbl_pkg::ST_STORE;
				end else begin
					pos = bits * (lvl - 1);
					digit = (pos >= 64) ? 64'd0 : ({16'd0, va} >> pos) & ((64'd1 << bits) - 1);
					blk = 64'(node_mem[blk[7:0]][digit[5:0]]);
				end
				lvl--;
			end
			if (r.status == rtbl_pkg::ST_OK)
				r.pba = blk[rtbl_pkg::PBA_OUT_W-1:0];
		end
		return r;
	endfunction

	// Entry for a walkable node: a walkable child or a block number past the store.
	function automatic logic [rtbl_pkg::ENTRY_IN_W-1:0] tree_entry();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 85)
			return {24'd0, walk_nodes[$urandom_range(0, 3)]};
		if (k < 88)
			return 32'hFFFF_FFFF;
		if (k < 91)
			return 32'd256;
		return $urandom_range(256, 32'hFFFF_FFFF);
	endfunction

	function automatic logic [rtbl_pkg::VBA_W-1:0] pick_vba(
			input logic [rtbl_pkg::LEAF_W-1:0] lim);
		logic [63:0] r;
		logic [rtbl_pkg::LEAF_W-1:0] cap;
		int unsigned k;
		r = {$urandom, $urandom};
		k = $urandom_range(0, 99);
		cap = (lim > ALL_LEAVES) ? ALL_LEAVES : lim;
		if (k < 5)
			return '0;
		if (k < 10)
			return '1;
		if (cap == 0 || k < 30)
			return r[rtbl_pkg::VBA_W-1:0];
		if (k < 35)
			return rtbl_pkg::VBA_W'(cap - 1);
		if (k < 40 && lim < ALL_LEAVES)
			return lim[rtbl_pkg::VBA_W-1:0];
		return rtbl_pkg::VBA_W'(r % 64'(cap));
	endfunction

	task automatic add_cmd(input logic f, input logic [rtbl_pkg::NODE_W-1:0] nb,
			input logic [rtbl_pkg::SLOT_IN_W-1:0] sl,
			input logic [rtbl_pkg::ENTRY_IN_W-1:0] ev,
			input logic [rtbl_pkg::VBA_W-1:0] va);
		job_t j;
		int unsigned k;
		k = $urandom_range(0, 99);
		j = '0;
		j.kind = JOB_CMD;
		j.func_b = f;
		j.nb = nb;
		j.sl = sl;
		j.ev = ev;
		j.va = va;
		if (!idle_on || k < 55)
			j.gap = 0;
		else if (k < 85)
			j.gap = 8'($urandom_range(1, 3));
		else if (k < 97)
			j.gap = 8'($urandom_range(4, 10));
		else
			j.gap = 8'($urandom_range(20, 60));
		job_q.push_back(j);
	endtask

	// unused payload fields carry random bits
	task automatic add_write(input logic [rtbl_pkg::NODE_W-1:0] nb,
			input logic [rtbl_pkg::SLOT_IN_W-1:0] sl,
			input logic [rtbl_pkg::ENTRY_IN_W-1:0] ev);
		add_cmd(rtbl_pkg::FUNC_WRITE, nb, sl, ev, rtbl_pkg::VBA_W'({$urandom, $urandom}));
	endtask

	task automatic add_lookup(input logic [rtbl_pkg::VBA_W-1:0] va);
		add_cmd(rtbl_pkg::FUNC_LOOKUP, rtbl_pkg::NODE_W'($urandom),
			rtbl_pkg::SLOT_IN_W'($urandom), $urandom, va);
	endtask

	task automatic add_reg_write(input logic [rtbl_pkg::CFG_IDX_W-1:0] idx,
			input logic [rtbl_pkg::CFG_DATA_W-1:0] d);
		job_t j;
		j = '0;
		j.kind = JOB_CFG;
		j.idx = idx;
		j.data = d;
		if (idx == rtbl_pkg::CFG_LEAVES)
			gen_leaves = d;
		job_q.push_back(j);
	endtask

	task automatic add_drain();
		job_t j;
		j = '0;
		j.kind = JOB_DRAIN;
		job_q.push_back(j);
	endtask

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Driver: one transaction held until taken, then the next after its gap.
	always @(negedge clk) begin
		job_t j;
		if (arst_n && !((start && !cmd_taken) || (cfg_valid && !cfg_taken))) begin
			if (job_q.size() == 0) begin
				start <= 1'b0;
				cfg_valid <= 1'b0;
			end else begin
				j = job_q[0];
				if (j.kind == JOB_DRAIN) begin
					start <= 1'b0;
					cfg_valid <= 1'b0;
					if (due_xlat.size() == 0 && !busy)
						j = job_q.pop_front();
				end else if (gap_waited < j.gap) begin
					gap_waited <= gap_waited + 8'd1;
					start <= 1'b0;
					cfg_valid <= 1'b0;
				end else begin
					j = job_q.pop_front();
					gap_waited <= '0;
					start <= (j.kind == JOB_CMD);
					cfg_valid <= (j.kind == JOB_CFG);
					func <= j.func_b;
					node_block <= j.nb;
					slot <= j.sl;
					entry_value <= j.ev;
					vba <= j.va;
					cfg_index <= j.idx;
					cfg_data <= j.data;
				end
			end
		end
	end

	// Monitor: predicts at acceptance, checks each result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		xlat_t want;
		if (!arst_n) begin
			cmd_taken <= 1'b0;
			cfg_taken <= 1'b0;
			idle_cycles <= 0;
			deg_reg = 3'd1;
			hgt_reg = 4'd1;
			leaves_reg = '0;
			root_reg = '0;
		end else begin
			cmd_taken <= start && !busy;
			cfg_taken <= cfg_valid && cfg_ready;
			if (done) begin
				if (due_xlat.size() == 0) begin
					flag_error($sformatf("unexpected result pba %h status %0d", pba, status));
				end else begin
					want = due_xlat.pop_front();
					if (pba !== want.pba)
						flag_error($sformatf("pba expected %h got %h", want.pba, pba));
					if (status !== want.status)
						flag_error($sformatf("status expected %0d got %0d",
							want.status, status));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rtbl_pkg::CFG_DEGREE: deg_reg = cfg_data[rtbl_pkg::DEG_REG_W-1:0];
					rtbl_pkg::CFG_HEIGHT: hgt_reg = cfg_data[rtbl_pkg::HGT_REG_W-1:0];
					rtbl_pkg::CFG_LEAVES: leaves_reg = cfg_data[rtbl_pkg::LEAF_W-1:0];
					rtbl_pkg::CFG_ROOT:   root_reg = cfg_data[rtbl_pkg::ROOT_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				due_xlat.push_back(translate_item(func, node_block, slot, entry_value, vba));
			if (done || (start && !busy) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [rtbl_pkg::NODE_W-1:0] nb;
		logic [rtbl_pkg::CFG_DATA_W-1:0] d;
		int unsigned k;
		int b, s, ph, n;

		walk_nodes[0] = 8'd0;
		walk_nodes[1] = 8'd255;
		walk_nodes[2] = 8'($urandom_range(1, 127));
		walk_nodes[3] = 8'($urandom_range(128, 254));

		// no leaves after reset: every lookup is out of range
		add_lookup('0);
		add_lookup('1);

		// every slot of each walkable node, so no walk reads an unwritten entry
		for (b = 0; b < 4; b++)
			for (s = 0; s < SLOTS; s++)
				add_write(walk_nodes[b], s[5:0], tree_entry());

		add_drain();
		add_reg_write(rtbl_pkg::CFG_DEGREE, 49'd6);
		add_reg_write(rtbl_pkg::CFG_HEIGHT, 49'd8);
		add_reg_write(rtbl_pkg::CFG_LEAVES, ALL_LEAVES);
		add_reg_write(rtbl_pkg::CFG_ROOT, 49'd255);
		add_write(8'd255, 6'd63, 32'hFFFF_FFFF);
		add_lookup('1);	// past the store at the second level
		add_lookup('0);
		add_write(8'd255, 6'd0, 32'd0);

		add_drain();
		add_reg_write(rtbl_pkg::CFG_HEIGHT, 49'd1);
		add_lookup(48'd63);
		add_lookup(48'd0);

		// degree and height of zero behave as one
		add_drain();
		add_reg_write(rtbl_pkg::CFG_DEGREE, 49'd0);
		add_reg_write(rtbl_pkg::CFG_HEIGHT, 49'd0);
		add_reg_write(rtbl_pkg::CFG_ROOT, 49'd0);
		add_reg_write(rtbl_pkg::CFG_LEAVES, 49'd1);
		add_lookup(48'd0);
		add_lookup(48'd1);

		// oversized degree and height are clipped
		add_drain();
		add_reg_write(rtbl_pkg::CFG_DEGREE, 49'd7);
		add_reg_write(rtbl_pkg::CFG_HEIGHT, 49'd15);
		add_reg_write(rtbl_pkg::CFG_LEAVES, LEAF_ONES);
		add_lookup('1);
		add_lookup(pick_vba(gen_leaves));

		add_drain();
		add_reg_write(rtbl_pkg::CFG_DEGREE, 49'd1);
		add_reg_write(rtbl_pkg::CFG_HEIGHT, 49'd1);
		add_write(8'd0, 6'd1, 32'd256);
		add_lookup(48'd1);

		for (ph = 0; ph < 12; ph++) begin
			add_drain();
			idle_on = ($urandom_range(0, 3) != 0);
			if (ph == 0 || $urandom_range(0, 9) < 6) begin
				d = $urandom_range(0, 1) ? rtbl_pkg::CFG_DATA_W'({$urandom, $urandom}) : '0;
				d[rtbl_pkg::DEG_REG_W-1:0] = rtbl_pkg::DEG_REG_W'($urandom_range(0, 7));
				add_reg_write(rtbl_pkg::CFG_DEGREE, d);
			end
			if (ph == 0 || $urandom_range(0, 9) < 6) begin
				d = $urandom_range(0, 1) ? rtbl_pkg::CFG_DATA_W'({$urandom, $urandom}) : '0;
				d[rtbl_pkg::HGT_REG_W-1:0] = rtbl_pkg::HGT_REG_W'($urandom_range(0, 15));
				add_reg_write(rtbl_pkg::CFG_HEIGHT, d);
			end
			if (ph == 0 || $urandom_range(0, 9) < 6) begin
				d = $urandom_range(0, 1) ? rtbl_pkg::CFG_DATA_W'({$urandom, $urandom}) : '0;
				d[rtbl_pkg::ROOT_W-1:0] = walk_nodes[$urandom_range(0, 3)];
				add_reg_write(rtbl_pkg::CFG_ROOT, d);
			end
			if (ph == 0 || $urandom_range(0, 9) < 6) begin
				k = $urandom_range(0, 9);
				d = rtbl_pkg::CFG_DATA_W'({$urandom, $urandom});
				if (k < 4)
					d = ALL_LEAVES;
				else if (k == 4)
					d = '0;
				else if (k == 5)
					d = rtbl_pkg::CFG_DATA_W'($urandom_range(1, 64));
				else if (k == 6)
					d = LEAF_ONES;
				else if (k < 9)
					d[rtbl_pkg::LEAF_W-1] = 1'b0;
				add_reg_write(rtbl_pkg::CFG_LEAVES, d);
			end
			for (n = 0; n < 32; n++) begin
				k = $urandom_range(0, 99);
				if (k < 70) begin
					add_lookup(pick_vba(gen_leaves));
				end else if (k < 85) begin
					add_write(walk_nodes[$urandom_range(0, 3)],
						rtbl_pkg::SLOT_IN_W'($urandom_range(0, 63)), tree_entry());
				end else begin
					// a node no walk reaches: any content
					nb = rtbl_pkg::NODE_W'($urandom);
					while (nb == walk_nodes[0] || nb == walk_nodes[1] ||
							nb == walk_nodes[2] || nb == walk_nodes[3])
						nb = rtbl_pkg::NODE_W'($urandom);
					add_write(nb, rtbl_pkg::SLOT_IN_W'($urandom_range(0, 63)), $urandom);
				end
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (job_q.size() != 0 || start || cfg_valid)
			@(posedge clk);
		while (due_xlat.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
